/* rtl/core/sha1_pkg.sv */
// Shared constants and control structs of the SHA-1 hash engine.
package sha1_pkg;

    localparam int WORD_W   = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS   = 80;
    localparam int ROUND_W  = 7;
    localparam int FILL_W   = 6;
    localparam int COUNT_W  = 61;
    localparam int DIGEST_W = 5 * WORD_W;

    localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
    localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    // Commands from the sequencer to the compression core
    typedef struct packed {
        logic              load;   // shift one message word into the schedule
        logic [WORD_W-1:0] word;
        logic              start;  // run 80 rounds on the loaded block
        logic              init;   // return chaining value to initial values
    } core_cmd_t;

    // Status from the compression core
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

/* rtl/core/sha1_core.sv */
// Iterative SHA-1 compression: one round per cycle on a shared round unit.
module sha1_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sha1_pkg::core_cmd_t          cmd,
    output sha1_pkg::core_stat_t         stat,
    output logic [sha1_pkg::DIGEST_W-1:0] digest
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_ADD
    } core_state_t;

    core_state_t                        state_reg;
    logic [sha1_pkg::ROUND_W-1:0]       round_reg;
    logic [sha1_pkg::WORD_W-1:0]        a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [sha1_pkg::WORD_W-1:0]        h_reg [5];
    logic [sha1_pkg::WORD_W-1:0]        w_reg [sha1_pkg::BLOCK_WORDS];

    logic [sha1_pkg::WORD_W-1:0]        f_val;
    logic [sha1_pkg::WORD_W-1:0]        k_val;
    logic [sha1_pkg::WORD_W-1:0]        w_mix;
    logic [sha1_pkg::WORD_W-1:0]        w_t;
    logic [sha1_pkg::WORD_W-1:0]        temp_next;

    // Round function and constant by round group
    always_comb begin
        if (round_reg < sha1_pkg::ROUND_W'(20)) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K0;
        end else if (round_reg < sha1_pkg::ROUND_W'(40)) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K1;
        end else if (round_reg < sha1_pkg::ROUND_W'(60)) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K3;
        end
    end

    // Message schedule over a 16-word window, oldest word at index 0
    assign w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_t   = (round_reg < sha1_pkg::ROUND_W'(sha1_pkg::BLOCK_WORDS)) ?
                   w_reg[0] : {w_mix[30:0], w_mix[31]};

    assign temp_next = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_t;

    // Sequence the rounds, shift the schedule, fold into the chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            h_reg[0]  <= sha1_pkg::IV0;
            h_reg[1]  <= sha1_pkg::IV1;
            h_reg[2]  <= sha1_pkg::IV2;
            h_reg[3]  <= sha1_pkg::IV3;
            h_reg[4]  <= sha1_pkg::IV4;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (cmd.init) begin
                        h_reg[0] <= sha1_pkg::IV0;
                        h_reg[1] <= sha1_pkg::IV1;
                        h_reg[2] <= sha1_pkg::IV2;
                        h_reg[3] <= sha1_pkg::IV3;
                        h_reg[4] <= sha1_pkg::IV4;
                    end
                    if (cmd.load) begin
                        for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
                            w_reg[i] <= w_reg[i+1];
                        end
                        w_reg[sha1_pkg::BLOCK_WORDS-1] <= cmd.word;
                    end
                    if (cmd.start) begin
                        a_reg     <= h_reg[0];
                        b_reg     <= h_reg[1];
                        c_reg     <= h_reg[2];
                        d_reg     <= h_reg[3];
                        e_reg     <= h_reg[4];
                        round_reg <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN: begin
                    for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[sha1_pkg::BLOCK_WORDS-1] <= w_t;
                    a_reg     <= temp_next;
                    b_reg     <= a_reg;
                    c_reg     <= {b_reg[1:0], b_reg[31:2]};
                    d_reg     <= c_reg;
                    e_reg     <= d_reg;
                    round_reg <= round_reg + sha1_pkg::ROUND_W'(1);
                    if (round_reg == sha1_pkg::LAST_ROUND) begin
                        state_reg <= C_ADD;
                    end
                end
                C_ADD: begin
                    h_reg[0]  <= h_reg[0] + a_reg;
                    h_reg[1]  <= h_reg[1] + b_reg;
                    h_reg[2]  <= h_reg[2] + c_reg;
                    h_reg[3]  <= h_reg[3] + d_reg;
                    h_reg[4]  <= h_reg[4] + e_reg;
                    round_reg <= '0;
                    state_reg <= C_IDLE;
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_ADD);
    assign digest    = {h_reg[4], h_reg[3], h_reg[2], h_reg[1], h_reg[0]};

endmodule

/* rtl/core/sha1_hash_engine.sv */
// Top level of the SHA-1 hash engine: byte packing, padding sequencer, digest output.
//
// Input channel (s_): one message byte per word in s_tdata, s_tuser = 1 when the
// byte belongs to the message, s_tlast = 1 on the final word of a message. A word
// with s_tuser = 0 and s_tlast = 1 ends the message without adding a byte.
// Output channel (m_): one word per message, the 160-bit digest, H0 in the low bits.
//
// Bytes are taken one per cycle while the block is collecting. When the 64th
// byte of a block arrives, s_tready drops while the 80 rounds of the single
// round unit run and their result is folded into the chaining value. On s_tlast
// the sequencer writes the 0x80 byte and zero bytes one per cycle until 56 bytes
// are held, then the two length words, compressing once more if the padding
// spills into a second block. After the final fold the sequencer enters S_OUT and,
// once the output register is free, registers the digest onto m_tdata with
// m_tvalid, and the next message starts from the initial values.
// If the receiver stalls, one digest is held in the output register while bytes
// of the next message are still taken; that message's digest waits until the
// register is free. Reset (aresetn low, synchronous) clears the chaining value,
// counters and m_tvalid.
module sha1_hash_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] byte_valid
    input  logic                          s_tlast,   // last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sha1_pkg::DIGEST_W-1:0] m_tdata    // [31:0] digest_word0 .. [159:128] digest_word4
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_PAD,
        S_LEN,
        S_OUT
    } seq_state_t;

    seq_state_t                           state_reg;
    logic [sha1_pkg::FILL_W-1:0]          fill_reg;
    logic [sha1_pkg::COUNT_W-1:0]         count_reg;
    logic [23:0]                          word_reg;
    logic                                 pad80_reg;
    logic                                 last_pend_reg;
    logic                                 fin_reg;
    logic                                 len_sel_reg;
    logic                                 m_tvalid_reg;
    logic [sha1_pkg::DIGEST_W-1:0]        m_tdata_reg;

    logic                                 s_accept;
    logic                                 push_byte;
    logic [7:0]                           push_data;
    logic                                 block_full;
    logic                                 out_load;
    logic [63:0]                          bit_len;
    sha1_pkg::core_cmd_t                  core_cmd;
    sha1_pkg::core_stat_t                 core_stat;
    logic [sha1_pkg::DIGEST_W-1:0]        core_digest;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Select the byte written this cycle: message byte or padding
    always_comb begin
        push_byte = 1'b0;
        push_data = s_tdata;
        case (state_reg)
            S_IDLE: begin
                push_byte = s_accept && s_tuser;
                push_data = s_tdata;
            end
            S_PAD: begin
                push_byte = 1'b1;
                push_data = pad80_reg ? sha1_pkg::PAD_BYTE : 8'h00;
            end
            default: begin
                push_byte = 1'b0;
                push_data = s_tdata;
            end
        endcase
    end

    assign block_full = push_byte && (fill_reg == sha1_pkg::FILL_W'(63));
    assign out_load   = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign bit_len    = {count_reg, 3'b000};

    // Drive the compression core
    always_comb begin
        core_cmd.load  = (push_byte && (fill_reg[1:0] == 2'b11)) || (state_reg == S_LEN);
        core_cmd.word  = {word_reg, push_data};
        if (state_reg == S_LEN) begin
            core_cmd.word = len_sel_reg ? bit_len[31:0] : bit_len[63:32];
        end
        core_cmd.start = block_full || ((state_reg == S_LEN) && len_sel_reg);
        core_cmd.init  = out_load;
    end

    sha1_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (core_cmd),
        .stat    (core_stat),
        .digest  (core_digest)
    );

    // Sequencer: collect bytes, pad, append length, emit digest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            pad80_reg     <= 1'b0;
            last_pend_reg <= 1'b0;
            fin_reg       <= 1'b0;
            len_sel_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            if (push_byte) begin
                word_reg <= {word_reg[15:0], push_data};
                fill_reg <= fill_reg + sha1_pkg::FILL_W'(1);
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser) begin
                            count_reg <= count_reg + sha1_pkg::COUNT_W'(1);
                        end
                        if (block_full) begin
                            last_pend_reg <= s_tlast;
                            pad80_reg     <= 1'b1;
                            fin_reg       <= 1'b0;
                            state_reg     <= S_COMP;
                        end else if (s_tlast) begin
                            pad80_reg <= 1'b1;
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_COMP: begin
                    if (core_stat.done) begin
                        if (fin_reg) begin
                            state_reg <= S_OUT;
                        end else if (last_pend_reg) begin
                            state_reg <= S_PAD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_PAD: begin
                    pad80_reg <= 1'b0;
                    if (fill_reg == sha1_pkg::FILL_W'(63)) begin
                        last_pend_reg <= 1'b1;
                        fin_reg       <= 1'b0;
                        state_reg     <= S_COMP;
                    end else if (fill_reg == sha1_pkg::FILL_W'(55)) begin
                        len_sel_reg <= 1'b0;
                        state_reg   <= S_LEN;
                    end
                end
                S_LEN: begin
                    len_sel_reg <= 1'b1;
                    if (len_sel_reg) begin
                        fin_reg   <= 1'b1;
                        fill_reg  <= '0;
                        state_reg <= S_COMP;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tdata_reg   <= core_digest;
                        m_tvalid_reg  <= 1'b1;
                        fill_reg      <= '0;
                        count_reg     <= '0;
                        last_pend_reg <= 1'b0;
                        fin_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/sha1_checker.sv */
// Port-level checks of the SHA-1 hash engine and their bind to the top level.
module sha1_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sha1_pkg::DIGEST_W-1:0] m_tdata
);

    // Hold a stalled digest word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled digest word changed");

    // Drop ready after the final word of a message
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready stayed high after end of message");

    // Keep ready after a word that carries neither byte nor end mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !s_tlast |=> s_tready)
        else $error("idle word stalled the input");

    // Clear the output after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("digest valid after reset");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (.*);
